>>> rtl/mbg_pkg.sv
// shared types, codes and helpers for the maze backtracker generator
`timescale 1ns / 1ps
`default_nettype none
package mbg_pkg;

	// internal coordinate width covers grids up to 127 cells on a side
	localparam int CW = 7;
	// coordinate width on the ports and of the start registers
	localparam int OW = 6;
	// configuration index width
	localparam int AW = 2;

	localparam logic [AW-1:0] REG_START_X = AW'(0);
	localparam logic [AW-1:0] REG_START_Y = AW'(1);

	typedef enum logic [1:0] {
		DIR_N = 2'd0,
		DIR_E = 2'd1,
		DIR_S = 2'd2,
		DIR_W = 2'd3
	} dir_t;

	// one stack entry: cell, shuffled direction order, next position to try
	typedef struct packed {
		logic [CW-1:0]     x;
		logic [CW-1:0]     y;
		logic [3:0][1:0]   order;
		logic [2:0]        next;
	} frame_t;

	typedef struct packed {
		logic          wr_en;
		logic          wr_val;
		logic [CW-1:0] wr_x;
		logic [CW-1:0] wr_y;
		logic          rd_en;
		logic [CW-1:0] rd_x;
		logic [CW-1:0] rd_y;
	} wall_req_t;

	// swap positions draw[i] and i for i = 0..3, starting from n, e, s, w
	function automatic logic [3:0][1:0] shuffle(input logic [3:0][1:0] draw);
		logic [3:0][1:0] ord;
		logic [1:0]      t;
		ord[0] = DIR_N;
		ord[1] = DIR_E;
		ord[2] = DIR_S;
		ord[3] = DIR_W;
		for (int i = 0; i < 4; i++) begin
			t = ord[draw[i]];
			ord[draw[i]] = ord[i];
			ord[i] = t;
		end
		return ord;
	endfunction

endpackage
`default_nettype wire

>>> rtl/mbg_wall_map.sv
// wall map memory, one bit per grid cell, with its clearing sweep
`timescale 1ns / 1ps
`default_nettype none
module mbg_wall_map #(
	parameter int GRID_W = 61,
	parameter int GRID_H = 61
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mbg_pkg::wall_req_t req,
	input  logic               clear_start,
	output logic               clear_busy,
	output logic               rd_wall
);

	localparam int NCELL = GRID_W * GRID_H;
	localparam int IW    = $clog2(NCELL);

	logic          mem [NCELL];
	logic [IW-1:0] clr_q;
	logic          busy_q;
	logic          rd_q;
	logic [IW-1:0] wr_idx;
	logic [IW-1:0] rd_idx;

	assign wr_idx = IW'(32'(req.wr_y) * 32'(GRID_W) + 32'(req.wr_x));
	assign rd_idx = IW'(32'(req.rd_y) * 32'(GRID_W) + 32'(req.rd_x));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (clear_start) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			if (clr_q == IW'(NCELL - 1))
				busy_q <= 1'b0;
			clr_q <= clr_q + IW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q)
			mem[clr_q] <= 1'b1;
		else if (req.wr_en)
			mem[wr_idx] <= req.wr_val;
		if (req.rd_en)
			rd_q <= mem[rd_idx];
	end

	assign clear_busy = busy_q;
	assign rd_wall    = rd_q;

endmodule
`default_nettype wire

>>> rtl/mbg_stack_ram.sv
// visit stack memory for entries below the cached top frame
`timescale 1ns / 1ps
`default_nettype none
module mbg_stack_ram #(
	parameter int STACK_DEPTH = 1024
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [$clog2(STACK_DEPTH)-1:0] wr_addr,
	input  mbg_pkg::frame_t                wr_data,
	input  logic                           rd_en,
	input  logic [$clog2(STACK_DEPTH)-1:0] rd_addr,
	output mbg_pkg::frame_t                rd_data
);

	mbg_pkg::frame_t mem [STACK_DEPTH];
	mbg_pkg::frame_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;

endmodule
`default_nettype wire

>>> rtl/maze_backtracker_generator.sv
// maze backtracker generator top level: walk sequencer, top frame and result register
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake              payload
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data (start_x, start_y)
// in        in         in_valid / in_stall    draw_0 .. draw_3
// out       out        out_valid / out_stall  wall_x, wall_y, cell_x, cell_y, finished
//
// an item passes through enter and walk, plus a walk step per direction off the grid, a walk,
// probe and check per direction probed in the wall map, a walk and for a deeper stack a load
// per pop, and a walk for the empty stack check at the finish, and ends in emit
// after reset and after every finished transaction the wall map is swept back to walls
// with in_stall high; configuration writes are always taken
// a result waits in the output register under out_stall; the next item is still accepted
module maze_backtracker_generator #(
	parameter int GRID_W      = 61,
	parameter int GRID_H      = 61,
	parameter int STACK_DEPTH = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [mbg_pkg::AW-1:0]     cfg_index,
	input  logic [mbg_pkg::OW-1:0]     cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 draw_0,
	input  logic [1:0]                 draw_1,
	input  logic [1:0]                 draw_2,
	input  logic [1:0]                 draw_3,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [mbg_pkg::OW-1:0]     wall_x,
	output logic [mbg_pkg::OW-1:0]     wall_y,
	output logic [mbg_pkg::OW-1:0]     cell_x,
	output logic [mbg_pkg::OW-1:0]     cell_y,
	output logic                       finished
);

	localparam int CW = mbg_pkg::CW;
	localparam int OW = mbg_pkg::OW;
	localparam int SW = $clog2(STACK_DEPTH);
	localparam int LW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_ENTER = 8'b0000_0100,
		S_WALK  = 8'b0000_1000,
		S_LOAD  = 8'b0001_0000,
		S_PROBE = 8'b0010_0000,
		S_CHECK = 8'b0100_0000,
		S_EMIT  = 8'b1000_0000
	} state_t;

	state_t                state_q;
	logic [OW-1:0]         start_x_q;
	logic [OW-1:0]         start_y_q;
	logic [CW-1:0]         pend_x_q;
	logic [CW-1:0]         pend_y_q;
	logic [3:0][1:0]       order_q;
	logic                  run_active_q;
	logic [LW-1:0]         level_q;
	mbg_pkg::frame_t       top_q;
	logic [CW-1:0]         wx_q;
	logic [CW-1:0]         wy_q;
	logic [CW-1:0]         tx_q;
	logic [CW-1:0]         ty_q;
	logic                  fin_q;
	logic                  out_valid_q;
	logic [OW-1:0]         out_wx_q;
	logic [OW-1:0]         out_wy_q;
	logic [OW-1:0]         out_cx_q;
	logic [OW-1:0]         out_cy_q;
	logic                  out_fin_q;

	logic                  in_fire;
	logic                  emit_fire;
	logic                  pend_inside;
	logic                  stack_full;
	mbg_pkg::wall_req_t    wall_req;
	logic                  clear_start;
	logic                  clear_busy;
	logic                  rd_wall;
	logic                  stk_wr_en;
	logic [SW-1:0]         stk_wr_addr;
	logic                  stk_rd_en;
	logic [SW-1:0]         stk_rd_addr;
	mbg_pkg::frame_t       stk_rd_data;
	mbg_pkg::dir_t         dir;
	logic                  step_ok;
	logic [CW-1:0]         step_wx;
	logic [CW-1:0]         step_wy;
	logic [CW-1:0]         step_tx;
	logic [CW-1:0]         step_ty;
	logic [LW-1:0]         level_dec;
	logic [LW-1:0]         level_dec2;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign emit_fire = (state_q == S_EMIT) && (!out_valid_q || !out_stall);

	assign pend_inside = (pend_x_q < CW'(GRID_W)) && (pend_y_q < CW'(GRID_H));
	assign stack_full  = (level_q == LW'(STACK_DEPTH));
	assign level_dec   = level_q - LW'(1);
	assign level_dec2  = level_q - LW'(2);

	// direction step from the top frame
	always_comb begin
		dir     = mbg_pkg::dir_t'(top_q.order[top_q.next[1:0]]);
		step_ok = 1'b0;
		step_wx = top_q.x;
		step_wy = top_q.y;
		step_tx = top_q.x;
		step_ty = top_q.y;
		unique case (dir)
			mbg_pkg::DIR_N: begin
				step_ok = (top_q.y >= CW'(2));
				step_wy = top_q.y - CW'(1);
				step_ty = top_q.y - CW'(2);
			end
			mbg_pkg::DIR_E: begin
				step_ok = (({1'b0, top_q.x} + (CW+1)'(2)) < (CW+1)'(GRID_W));
				step_wx = top_q.x + CW'(1);
				step_tx = top_q.x + CW'(2);
			end
			mbg_pkg::DIR_S: begin
				step_ok = (({1'b0, top_q.y} + (CW+1)'(2)) < (CW+1)'(GRID_H));
				step_wy = top_q.y + CW'(1);
				step_ty = top_q.y + CW'(2);
			end
			mbg_pkg::DIR_W: begin
				step_ok = (top_q.x >= CW'(2));
				step_wx = top_q.x - CW'(1);
				step_tx = top_q.x - CW'(2);
			end
			default: begin
				step_ok = 1'b0;
			end
		endcase
	end

	// memory requests
	always_comb begin
		wall_req        = '0;
		wall_req.rd_x   = tx_q;
		wall_req.rd_y   = ty_q;
		wall_req.rd_en  = (state_q == S_PROBE);
		wall_req.wr_val = 1'b0;
		if (state_q == S_ENTER) begin
			wall_req.wr_en = pend_inside;
			wall_req.wr_x  = pend_x_q;
			wall_req.wr_y  = pend_y_q;
		end else begin
			wall_req.wr_en = (state_q == S_CHECK) && rd_wall;
			wall_req.wr_x  = wx_q;
			wall_req.wr_y  = wy_q;
		end
		clear_start = emit_fire && fin_q;

		// the cached top frame spills to memory on a push
		stk_wr_en   = (state_q == S_ENTER) && pend_inside && !stack_full && (level_q != '0);
		stk_wr_addr = level_dec[SW-1:0];
		// a pop refills the top from the entry below
		stk_rd_en   = (state_q == S_WALK) && (level_q != '0) && top_q.next[2]
			&& (level_q > LW'(1));
		stk_rd_addr = level_dec2[SW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			start_x_q    <= OW'(1);
			start_y_q    <= OW'(1);
			pend_x_q     <= CW'(1);
			pend_y_q     <= CW'(1);
			run_active_q <= 1'b0;
			level_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					mbg_pkg::REG_START_X: start_x_q <= cfg_data;
					mbg_pkg::REG_START_Y: start_y_q <= cfg_data;
					default: ;
				endcase
			end

			if (emit_fire)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_CLEAR: begin
					if (!clear_busy)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_fire) begin
						if (!run_active_q) begin
							pend_x_q     <= CW'(start_x_q);
							pend_y_q     <= CW'(start_y_q);
							run_active_q <= 1'b1;
						end
						state_q <= S_ENTER;
					end
				end
				S_ENTER: begin
					if (pend_inside && !stack_full)
						level_q <= level_q + LW'(1);
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (level_q == '0) begin
						run_active_q <= 1'b0;
						state_q      <= S_EMIT;
					end else if (top_q.next[2]) begin
						level_q <= level_dec;
						state_q <= (level_q > LW'(1)) ? S_LOAD : S_WALK;
					end else begin
						state_q <= step_ok ? S_PROBE : S_WALK;
					end
				end
				S_LOAD: begin
					state_q <= S_WALK;
				end
				S_PROBE: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (rd_wall) begin
						pend_x_q <= tx_q;
						pend_y_q <= ty_q;
						state_q  <= S_EMIT;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_EMIT: begin
					if (emit_fire)
						state_q <= fin_q ? S_CLEAR : S_IDLE;
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire)
			order_q <= mbg_pkg::shuffle({draw_3, draw_2, draw_1, draw_0});

		if (state_q == S_ENTER && pend_inside && !stack_full) begin
			top_q.x     <= pend_x_q;
			top_q.y     <= pend_y_q;
			top_q.order <= order_q;
			top_q.next  <= 3'd0;
		end else if (state_q == S_LOAD) begin
			top_q <= stk_rd_data;
		end else if (state_q == S_WALK && level_q != '0 && !top_q.next[2]) begin
			top_q.next <= top_q.next + 3'd1;
		end

		if (state_q == S_WALK) begin
			wx_q  <= step_wx;
			wy_q  <= step_wy;
			tx_q  <= step_tx;
			ty_q  <= step_ty;
			fin_q <= (level_q == '0);
		end else if (state_q == S_CHECK) begin
			fin_q <= 1'b0;
		end

		if (emit_fire) begin
			out_wx_q  <= fin_q ? '0 : wx_q[OW-1:0];
			out_wy_q  <= fin_q ? '0 : wy_q[OW-1:0];
			out_cx_q  <= fin_q ? '0 : tx_q[OW-1:0];
			out_cy_q  <= fin_q ? '0 : ty_q[OW-1:0];
			out_fin_q <= fin_q;
		end
	end

	mbg_wall_map #(
		.GRID_W (GRID_W),
		.GRID_H (GRID_H)
	) u_wall_map (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (wall_req),
		.clear_start (clear_start),
		.clear_busy  (clear_busy),
		.rd_wall     (rd_wall)
	);

	mbg_stack_ram #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk     (clk),
		.wr_en   (stk_wr_en),
		.wr_addr (stk_wr_addr),
		.wr_data (top_q),
		.rd_en   (stk_rd_en),
		.rd_addr (stk_rd_addr),
		.rd_data (stk_rd_data)
	);

	assign out_valid = out_valid_q;
	assign wall_x    = out_wx_q;
	assign wall_y    = out_wy_q;
	assign cell_x    = out_cx_q;
	assign cell_y    = out_cy_q;
	assign finished  = out_fin_q;

endmodule
`default_nettype wire

>>> bench/tb_top.sv
// self-checking bench for the maze backtracker generator: carve predictor, driver, monitor
`timescale 1ns / 1ps
module tb_top;

	localparam int MAZE_W      = 61;
	localparam int MAZE_H      = 61;
	localparam int TRAIL_DEPTH = 1024;
	localparam int QUIET_LIMIT = 100000;
	localparam int HOLD_CYCLES = 500;

	// indexes that the block must ignore
	localparam logic [mbg_pkg::AW-1:0] REG_SPARE_A = mbg_pkg::AW'(2);
	localparam logic [mbg_pkg::AW-1:0] REG_SPARE_B = mbg_pkg::AW'(3);

	typedef logic [3:0][1:0] draw_set_t;

	typedef struct packed {
		logic [mbg_pkg::OW-1:0] wall_x;
		logic [mbg_pkg::OW-1:0] wall_y;
		logic [mbg_pkg::OW-1:0] cell_x;
		logic [mbg_pkg::OW-1:0] cell_y;
		logic                   finished;
	} carve_result_t;

	// first carving steps from the far corner: uniform, rotated and reversed draws
	localparam draw_set_t OPENING_DRAWS [16] = '{
		{2'd0, 2'd0, 2'd0, 2'd0}, {2'd3, 2'd3, 2'd3, 2'd3},
		{2'd1, 2'd1, 2'd1, 2'd1}, {2'd2, 2'd2, 2'd2, 2'd2},
		{2'd0, 2'd3, 2'd2, 2'd1}, {2'd0, 2'd1, 2'd2, 2'd3},
		{2'd3, 2'd2, 2'd1, 2'd0}, {2'd1, 2'd0, 2'd3, 2'd2},
		{2'd2, 2'd3, 2'd0, 2'd1}, {2'd2, 2'd1, 2'd0, 2'd3},
		{2'd1, 2'd3, 2'd0, 2'd2}, {2'd2, 2'd1, 2'd3, 2'd0},
		{2'd2, 2'd0, 2'd3, 2'd1}, {2'd0, 2'd2, 2'd1, 2'd3},
		{2'd3, 2'd0, 2'd1, 2'd2}, {2'd1, 2'd3, 2'd2, 2'd0}
	};

	// start points: just right of the grid, below it, far odd corner, even edge
	localparam logic [mbg_pkg::OW-1:0] START_X [4] = '{6'd61, 6'd0, 6'd59, 6'd60};
	localparam logic [mbg_pkg::OW-1:0] START_Y [4] = '{6'd5, 6'd63, 6'd59, 6'd0};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [mbg_pkg::AW-1:0] cfg_index = '0;
	logic [mbg_pkg::OW-1:0] cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [1:0]             draw_0 = '0;
	logic [1:0]             draw_1 = '0;
	logic [1:0]             draw_2 = '0;
	logic [1:0]             draw_3 = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [mbg_pkg::OW-1:0] wall_x;
	logic [mbg_pkg::OW-1:0] wall_y;
	logic [mbg_pkg::OW-1:0] cell_x;
	logic [mbg_pkg::OW-1:0] cell_y;
	logic                   finished;

	draw_set_t     draw_queue [$];
	carve_result_t carve_expected [$];
	int            items_in = 0;
	int            errors = 0;
	int            quiet_cycles = 0;
	int            hold_left = 0;
	bit            hold_done = 1'b0;
	int            sender_idle;
	int            receiver_idle;

	// predictor state
	bit                     walled [MAZE_H][MAZE_W];
	mbg_pkg::frame_t        trail [TRAIL_DEPTH];
	int unsigned            depth_used = 0;
	int unsigned            next_x = 1;
	int unsigned            next_y = 1;
	bit                     maze_live = 1'b0;
	logic [mbg_pkg::OW-1:0] origin_x = 6'd1;
	logic [mbg_pkg::OW-1:0] origin_y = 6'd1;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	maze_backtracker_generator #(
		.GRID_W(MAZE_W),
		.GRID_H(MAZE_H),
		.STACK_DEPTH(TRAIL_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.draw_0(draw_0),
		.draw_1(draw_1),
		.draw_2(draw_2),
		.draw_3(draw_3),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.wall_x(wall_x),
		.wall_y(wall_y),
		.cell_x(cell_x),
		.cell_y(cell_y),
		.finished(finished)
	);

	// enter the pending cell, then walk and backtrack to the next carve
	function automatic carve_result_t carve_step(input draw_set_t draw);
		carve_result_t res;
		logic [3:0][1:0] ord;
		logic [1:0] t;
		logic [1:0] d;
		int unsigned top, x, y, wx, wy, tx, ty;
		bit ok;
		res = '0;
		res.finished = 1'b1;
		if (!maze_live) begin
			foreach (walled[r, c])
				walled[r][c] = 1'b1;
			depth_used = 0;
			next_x = 32'(origin_x);
			next_y = 32'(origin_y);
			maze_live = 1'b1;
		end
		if (next_x < MAZE_W && next_y < MAZE_H) begin
			walled[next_y][next_x] = 1'b0;
			// a full trail still opens the cell but never explores from it
			if (depth_used < TRAIL_DEPTH) begin
				ord[0] = mbg_pkg::DIR_N;
				ord[1] = mbg_pkg::DIR_E;
				ord[2] = mbg_pkg::DIR_S;
				ord[3] = mbg_pkg::DIR_W;
				for (int i = 0; i < 4; i++) begin
					t = ord[draw[i]];
					ord[draw[i]] = ord[i];
					ord[i] = t;
				end
				trail[depth_used].x = next_x[mbg_pkg::CW-1:0];
				trail[depth_used].y = next_y[mbg_pkg::CW-1:0];
				trail[depth_used].order = ord;
				trail[depth_used].next = '0;
				depth_used++;
			end
		end
		while (depth_used > 0) begin
			top = depth_used - 1;
			if (trail[top].next >= 3'd4) begin
				depth_used--;
				continue;
			end
			d = trail[top].order[trail[top].next[1:0]];
			trail[top].next = trail[top].next + 3'd1;
			x = 32'(trail[top].x);
			y = 32'(trail[top].y);
			wx = x;
			wy = y;
			tx = x;
			ty = y;
			ok = 1'b0;
			case (d)
				mbg_pkg::DIR_N: if (y >= 2) begin
					wy = y - 1;
					ty = y - 2;
					ok = 1'b1;
				end
				mbg_pkg::DIR_E: if (x + 2 < MAZE_W) begin
					wx = x + 1;
					tx = x + 2;
					ok = 1'b1;
				end
				mbg_pkg::DIR_S: if (y + 2 < MAZE_H) begin
					wy = y + 1;
					ty = y + 2;
					ok = 1'b1;
				end
				default: if (x >= 2) begin
					wx = x - 1;
					tx = x - 2;
					ok = 1'b1;
				end
			endcase
			if (ok && walled[ty][tx]) begin
				walled[wy][wx] = 1'b0;
				next_x = tx;
				next_y = ty;
				res.wall_x = wx[mbg_pkg::OW-1:0];
				res.wall_y = wy[mbg_pkg::OW-1:0];
				res.cell_x = tx[mbg_pkg::OW-1:0];
				res.cell_y = ty[mbg_pkg::OW-1:0];
				res.finished = 1'b0;
				return res;
			end
		end
		maze_live = 1'b0;
		return res;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// spare indexes first, then the start point; called right after a rising edge
	task automatic write_start(input logic [mbg_pkg::OW-1:0] sx,
			input logic [mbg_pkg::OW-1:0] sy);
		logic [mbg_pkg::AW-1:0] idx [4];
		logic [mbg_pkg::OW-1:0] val [4];
		idx = '{REG_SPARE_A, REG_SPARE_B, mbg_pkg::REG_START_X, mbg_pkg::REG_START_Y};
		val = '{mbg_pkg::OW'($urandom_range(63)), mbg_pkg::OW'($urandom_range(63)), sx, sy};
		for (int k = 0; k < 4; k++) begin
			cfg_index <= idx[k];
			cfg_data <= val[k];
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
			case (idx[k])
				mbg_pkg::REG_START_X: origin_x = val[k];
				mbg_pkg::REG_START_Y: origin_y = val[k];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	assign sender_idle = (items_in < 640) ? 30 : (items_in < 1280) ? 71 : 0;
	assign receiver_idle = (items_in < 640) ? 71 : (items_in < 1280) ? 30 : 0;

	always @(posedge clk or negedge arst_n) begin : drive_draws
		draw_set_t item;
		if (!arst_n) begin
			in_valid <= 1'b0;
			draw_0 <= '0;
			draw_1 <= '0;
			draw_2 <= '0;
			draw_3 <= '0;
			items_in <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				carve_expected.push_back(carve_step({draw_3, draw_2, draw_1, draw_0}));
				items_in <= items_in + 1;
			end
			if (!in_valid || !in_stall) begin
				if (draw_queue.size() != 0 && $urandom_range(99) >= sender_idle) begin
					item = draw_queue.pop_front();
					draw_0 <= item[0];
					draw_1 <= item[1];
					draw_2 <= item[2];
					draw_3 <= item[3];
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// one long hold-off early in the corner maze lets the block back up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && items_in >= 80) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < receiver_idle);
		end
	end

	always @(posedge clk) begin : watch_results
		carve_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (carve_expected.size() == 0) begin
				$error("result transaction with no item waiting: wall %0d,%0d cell %0d,%0d fin %0b",
					wall_x, wall_y, cell_x, cell_y, finished);
				errors++;
			end else begin
				want = carve_expected.pop_front();
				check_field("wall_x", 8'(want.wall_x), 8'(wall_x));
				check_field("wall_y", 8'(want.wall_y), 8'(wall_y));
				check_field("cell_x", 8'(want.cell_x), 8'(cell_x));
				check_field("cell_y", 8'(want.cell_y), 8'(cell_y));
				check_field("finished", 8'(want.finished), 8'(finished));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int n_items;
		int sx, sy;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < 4; p++) begin
			@(posedge clk);
			write_start(START_X[p], START_Y[p]);
			sx = int'(START_X[p]);
			sy = int'(START_Y[p]);
			// a start outside the grid finishes at once, else one item per reachable cell
			if (sx >= MAZE_W || sy >= MAZE_H)
				n_items = 1;
			else
				n_items = ((MAZE_W - sx % 2 + 1) / 2) * ((MAZE_H - sy % 2 + 1) / 2);
			for (int n = 0; n < n_items; n++) begin
				if (p == 2 && n < 16)
					draw_queue.push_back(OPENING_DRAWS[n]);
				else
					draw_queue.push_back(draw_set_t'($urandom));
			end
			do @(posedge clk);
			while (draw_queue.size() != 0 || in_valid || carve_expected.size() != 0);
			repeat (20) @(posedge clk);
		end
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> maze_backtracker_generator.f
rtl/mbg_pkg.sv
rtl/mbg_wall_map.sv
rtl/mbg_stack_ram.sv
rtl/maze_backtracker_generator.sv
bench/tb_top.sv
